### hw/rtl/ftmh_pkg.sv
// ftmh_pkg: shared constants of the flow tuple hash pipeline.
// Message kind codes and the 64-bit mixing multiplier.
// No dependencies.
package ftmh_pkg;

    localparam int unsigned KIND_W = 2;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PORT_W = 16;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    // message kinds
    localparam logic [KIND_W-1:0] KIND_USER     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INTERNAL = 2'd1;

    localparam logic [WORD_W-1:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int unsigned       MIX_SHIFT = 47;

    // key length (16 bytes) times the multiplier, i.e. a shift by four
    localparam logic [WORD_W-1:0] SEED_TWEAK = MIX_MUL << 4;

    localparam logic [HALF_W-1:0] MUL_LO = MIX_MUL[31:0];
    localparam logic [HALF_W-1:0] MUL_HI = MIX_MUL[63:32];

endpackage

### hw/rtl/ftmh_tuple_if.sv
// ftmh_tuple_if: valid/ready channel carrying one connection tuple beat.
// Depends on ftmh_pkg for field widths.
interface ftmh_tuple_if import ftmh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] req_type;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;

    modport source (
        output valid, req_type, src_addr, dst_addr, src_port, dst_port,
        input  ready
    );
    modport sink (
        input  valid, req_type, src_addr, dst_addr, src_port, dst_port,
        output ready
    );
endinterface

### hw/rtl/ftmh_hash_if.sv
// ftmh_hash_if: valid/ready channel carrying one 64-bit flow hash beat.
// Depends on ftmh_pkg for the word width.
interface ftmh_hash_if import ftmh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] flow_hash;

    modport source (output valid, flow_hash, input ready);
    modport sink (input valid, flow_hash, output ready);
endinterface

### hw/rtl/ftmh_key.sv
// ftmh_key: selects the tuple by message kind and forms the 16-byte key.
// One register stage. Depends on ftmh_pkg.
module ftmh_key import ftmh_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] req_type,
    input  logic [ADDR_W-1:0] src_addr,
    input  logic [ADDR_W-1:0] dst_addr,
    input  logic [PORT_W-1:0] src_port,
    input  logic [PORT_W-1:0] dst_port,
    output logic              out_valid,
    output logic [WORD_W-1:0] key_w0,
    output logic [WORD_W-1:0] key_w1
);

    logic [ADDR_W-1:0] sa, da;
    logic [PORT_W-1:0] sp, dp;
    logic              valid_reg;
    logic [WORD_W-1:0] w0_reg, w0_next;
    logic [WORD_W-1:0] w1_reg, w1_next;

    always_comb
    begin
        case (req_type)
            KIND_USER:
            begin
                sa = src_addr;
                da = dst_addr;
                sp = src_port;
                dp = dst_port;
            end
            KIND_INTERNAL:
            begin
                sa = '0;
                da = '0;
                sp = '0;
                dp = '0;
            end
            default:
            begin
                sa = '1;
                da = '1;
                sp = '1;
                dp = '1;
            end
        endcase
    end

    assign w0_next = WORD_W'(sa) * WORD_W'(da);
    assign w1_next = {sa ^ da, HALF_W'(sp) * HALF_W'(dp)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w0_reg <= w0_next;
            w1_reg <= w1_next;
        end
    end

    assign out_valid = valid_reg;
    assign key_w0    = w0_reg;
    assign key_w1    = w1_reg;

endmodule

### hw/rtl/ftmh_mul64.sv
// ftmh_mul64: two-stage (a ^ b) * MIX_MUL, low 64 bits kept.
// Stage 1: 32x32 partial products; stage 2: sum. Depends on ftmh_pkg.
module ftmh_mul64 import ftmh_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [WORD_W-1:0] op_a,
    input  logic [WORD_W-1:0] op_b,
    output logic              out_valid,
    output logic [WORD_W-1:0] product
);

    logic [WORD_W-1:0] x;
    logic              v1_reg, v2_reg;
    logic [WORD_W-1:0] lo_reg, lo_next;
    logic [HALF_W-1:0] cra_reg, cra_next;
    logic [HALF_W-1:0] crb_reg, crb_next;
    logic [WORD_W-1:0] prod_reg, prod_next;

    assign x = op_a ^ op_b;

    // only the low halves of the cross products reach the kept 64 bits
    assign lo_next  = WORD_W'(x[31:0]) * WORD_W'(MUL_LO);
    assign cra_next = x[63:32] * MUL_LO;
    assign crb_next = x[31:0] * MUL_HI;

    assign prod_next = lo_reg + {cra_reg + crb_reg, HALF_W'(0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg   <= lo_next;
            cra_reg  <= cra_next;
            crb_reg  <= crb_next;
            prod_reg <= prod_next;
        end
    end

    assign out_valid = v2_reg;
    assign product   = prod_reg;

endmodule

### hw/rtl/flow_tuple_murmur_hash.sv
// flow_tuple_murmur_hash: top level of the 64-bit flow tuple hash pipeline.
// Depends on ftmh_pkg, ftmh_tuple_if, ftmh_hash_if, ftmh_key, ftmh_mul64.
//
//   channel   dir   handshake         payload
//   tuple     in    valid/ready       req_type, src_addr, dst_addr, src_port, dst_port
//   hash      out   valid/ready       flow_hash
//   cfg       in    cfg_we            cfg_wdata (hash seed, 64 bits)
//
// One beat enters per cycle while tuple.ready is high; the path is a key stage,
// seven two-stage constant multipliers in five serial steps, one output register.
// The depth is set by the five dependent 64-bit multiplies, each split into
// 32x32 partial products and a sum.
// Reset clears every valid bit and sets the seed to zero.
// A stall on the hash side freezes the whole pipeline in place; tuple.ready
// is low only while the output register holds a beat that is not taken.
module flow_tuple_murmur_hash import ftmh_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [WORD_W-1:0]  cfg_wdata,
    ftmh_tuple_if.sink         tuple,
    ftmh_hash_if.source        hash
);

    logic              en;
    logic [WORD_W-1:0] seed_reg;

    logic              key_valid;
    logic [WORD_W-1:0] key_w0, key_w1;

    logic              ma0_valid, ma1_valid;
    logic [WORD_W-1:0] ma0_prod, ma1_prod;
    logic              mb0_valid, mb1_valid;
    logic [WORD_W-1:0] mb0_prod, mb1_prod;
    logic [WORD_W-1:0] mix1_d1_reg, mix1_d2_reg;

    logic              h1_valid, h2_valid, h3_valid;
    logic [WORD_W-1:0] h1_prod, h2_prod, h3_prod;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_hash_reg, out_hash_next;

    // whole-pipeline advance: move unless the output beat is stuck
    assign en          = !out_valid_reg || hash.ready;
    assign tuple.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_we)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    // key: kind select, address product, port product, address xor
    ftmh_key u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tuple.valid),
        .req_type  (tuple.req_type),
        .src_addr  (tuple.src_addr),
        .dst_addr  (tuple.dst_addr),
        .src_port  (tuple.src_port),
        .dst_port  (tuple.dst_port),
        .out_valid (key_valid),
        .key_w0    (key_w0),
        .key_w1    (key_w1)
    );

    // word mix, first multiply; both key words in parallel
    ftmh_mul64 u_mix_a0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (key_valid),
        .op_a      (key_w0),
        .op_b      ('0),
        .out_valid (ma0_valid),
        .product   (ma0_prod)
    );

    ftmh_mul64 u_mix_a1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (key_valid),
        .op_a      (key_w1),
        .op_b      ('0),
        .out_valid (ma1_valid),
        .product   (ma1_prod)
    );

    // word mix, xor-shift then second multiply
    ftmh_mul64 u_mix_b0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ma0_valid),
        .op_a      (ma0_prod),
        .op_b      (ma0_prod >> MIX_SHIFT),
        .out_valid (mb0_valid),
        .product   (mb0_prod)
    );

    ftmh_mul64 u_mix_b1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ma1_valid),
        .op_a      (ma1_prod),
        .op_b      (ma1_prod >> MIX_SHIFT),
        .out_valid (mb1_valid),
        .product   (mb1_prod)
    );

    // second mixed word waits two stages for the first hash multiply
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mix1_d1_reg <= mb1_prod;
            mix1_d2_reg <= mix1_d1_reg;
        end
    end

    // h = (seed ^ 16*M) ^ mix0, times M
    ftmh_mul64 u_hash_1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mb0_valid),
        .op_a      (seed_reg ^ SEED_TWEAK),
        .op_b      (mb0_prod),
        .out_valid (h1_valid),
        .product   (h1_prod)
    );

    // h ^= mix1, times M
    ftmh_mul64 u_hash_2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h1_valid),
        .op_a      (h1_prod),
        .op_b      (mix1_d2_reg),
        .out_valid (h2_valid),
        .product   (h2_prod)
    );

    // finalization: xor-shift, times M
    ftmh_mul64 u_hash_3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h2_valid),
        .op_a      (h2_prod),
        .op_b      (h2_prod >> MIX_SHIFT),
        .out_valid (h3_valid),
        .product   (h3_prod)
    );

    // last xor-shift lands in the output register
    assign out_hash_next = h3_prod ^ (h3_prod >> MIX_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= h3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hash_reg <= out_hash_next;
        end
    end

    assign hash.valid     = out_valid_reg;
    assign hash.flow_hash = out_hash_reg;

`ifndef SYNTHESIS
    // internal messages hash an all-zero key
    a_key_internal: assert property (@(posedge clk) disable iff (!rst_n)
        (tuple.valid && tuple.ready && tuple.req_type == KIND_INTERNAL)
        |=> (key_valid && key_w0 == '0 && key_w1 == '0))
        else $error("internal beat did not give a zero key");

    // other kinds hash the all-ones tuple
    a_key_other: assert property (@(posedge clk) disable iff (!rst_n)
        (tuple.valid && tuple.ready && tuple.req_type != KIND_USER
            && tuple.req_type != KIND_INTERNAL)
        |=> (key_valid && key_w0 == 64'hFFFFFFFE00000001
            && key_w1 == 64'h00000000FFFE0001))
        else $error("other-kind beat did not give the all-ones key");

    // the two word-mix lanes stay in lockstep
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (mb0_valid == mb1_valid) && (ma0_valid == ma1_valid))
        else $error("word-mix lanes out of step");

    // a frozen pipeline keeps its output beat
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (out_valid_reg && $stable(out_hash_reg)))
        else $error("output beat changed while stalled");
`endif

endmodule

### tb/sv/tb_flow_tuple_murmur_hash.sv
// tb_flow_tuple_murmur_hash: self-checking bench for the flow tuple hash pipeline.
// Drives tuple beats and seed writes, predicts each 64-bit hash and checks it in order.
// Depends on ftmh_pkg, ftmh_tuple_if, ftmh_hash_if and flow_tuple_murmur_hash.
module tb_flow_tuple_murmur_hash;
    timeunit 1ns;
    timeprecision 1ps;

    import ftmh_pkg::*;

    localparam int unsigned HALF_PERIOD = 5;
    localparam int unsigned RESET_CYCLES = 11;
    // pipeline depth of the block, plus a little margin for drains
    localparam int unsigned LATENCY = 12;
    localparam int unsigned SETTLE_CYCLES = LATENCY + 4;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned RANDOM_PHASES = 4;

    // kinds the package does not name: anything past internal counts as "other"
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // hash constants of the predictor
    localparam logic [WORD_W-1:0] MURMUR_M = 64'hc6a4a7935bd1e995;
    localparam int unsigned MURMUR_R = 47;
    localparam logic [WORD_W-1:0] KEY_LEN = 64'd16;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
    } tuple_t;

    // receiver stall patterns; each one runs for a random stretch
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } rx_mode_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [WORD_W-1:0] cfg_wdata;

    ftmh_tuple_if tuple_ch ();
    ftmh_hash_if  hash_ch ();

    flow_tuple_murmur_hash dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .tuple     (tuple_ch),
        .hash      (hash_ch)
    );

    // Seed as the block should hold it; only changed while the pipe is empty.
    logic [WORD_W-1:0] seed_shadow = '0;
    // Hashes owed by the block, oldest first.
    logic [WORD_W-1:0] owed_hashes[$];
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;

    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;
    int unsigned rx_phase = 0;
    logic        hold_active = 1'b0;
    event        hold_go;

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Hash predictor
    // ------------------------------------------------------------------

    // MurmurHash64A per-word scramble
    function automatic logic [WORD_W-1:0] scramble_word(input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] m;
        m = k * MURMUR_M;
        m = m ^ (m >> MURMUR_R);
        return m * MURMUR_M;
    endfunction

    // Builds the 16-byte key (two little-endian words) and hashes it.
    function automatic logic [WORD_W-1:0] murmur_flow_hash(input tuple_t t,
                                                           input logic [WORD_W-1:0] seed);
        logic [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0] da;
        logic [PORT_W-1:0] sp;
        logic [PORT_W-1:0] dp;
        logic [WORD_W-1:0] lo_word;
        logic [WORD_W-1:0] hi_word;
        logic [WORD_W-1:0] h;
        // internal traffic hashes as an all-zero tuple, any unknown kind
        // (including the spare code) as all-ones addresses and ports
        case (t.kind)
            KIND_USER:
            begin
                sa = t.src_addr;
                da = t.dst_addr;
                sp = t.src_port;
                dp = t.dst_port;
            end
            KIND_INTERNAL:
            begin
                sa = '0;
                da = '0;
                sp = '0;
                dp = '0;
            end
            default:
            begin
                sa = '1;
                da = '1;
                sp = '1;
                dp = '1;
            end
        endcase
        // bytes 0..7: full address product; 8..11: port product; 12..15: address xor
        lo_word = {32'b0, sa} * {32'b0, da};
        hi_word = {sa ^ da, {16'b0, sp} * {16'b0, dp}};
        h = seed ^ (KEY_LEN * MURMUR_M);
        h = h ^ scramble_word(lo_word);
        h = h * MURMUR_M;
        h = h ^ scramble_word(hi_word);
        h = h * MURMUR_M;
        h = h ^ (h >> MURMUR_R);
        h = h * MURMUR_M;
        h = h ^ (h >> MURMUR_R);
        return h;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic tuple_t make_tuple(input logic [KIND_W-1:0] kind,
                                          input logic [ADDR_W-1:0] sa,
                                          input logic [ADDR_W-1:0] da,
                                          input logic [PORT_W-1:0] sp,
                                          input logic [PORT_W-1:0] dp);
        tuple_t t;
        t.kind = kind;
        t.src_addr = sa;
        t.dst_addr = da;
        t.src_port = sp;
        t.dst_port = dp;
        return t;
    endfunction

    // addresses: mostly random, with zero and all-ones mixed in
    function automatic logic [ADDR_W-1:0] pick_addr();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return PORT_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // user data dominates; the other kinds still see random garbage fields
    function automatic tuple_t random_tuple();
        tuple_t      t;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            t.kind = KIND_USER;
        else if (sel == 7)
            t.kind = KIND_INTERNAL;
        else if (sel == 8)
            t.kind = KIND_OTHER;
        else
            t.kind = KIND_SPARE;
        t.src_addr = pick_addr();
        t.dst_addr = pick_addr();
        t.src_port = pick_port();
        t.dst_port = pick_port();
        return t;
    endfunction

    // One beat: offered at the falling edge, held until taken at a rising edge.
    // Valid is left high so back-to-back beats need no extra edge.
    task automatic send_tuple(input tuple_t t);
        @(negedge clk);
        tuple_ch.valid    <= 1'b1;
        tuple_ch.req_type <= t.kind;
        tuple_ch.src_addr <= t.src_addr;
        tuple_ch.dst_addr <= t.dst_addr;
        tuple_ch.src_port <= t.src_port;
        tuple_ch.dst_port <= t.dst_port;
        do
            @(posedge clk);
        while (!tuple_ch.ready);
        owed_hashes.push_back(murmur_flow_hash(t, seed_shadow));
    endtask

    // Drops valid for a number of cycles; zero keeps the stream going.
    task automatic pause_sender(input int unsigned cycles);
        if (cycles == 0)
            return;
        @(negedge clk);
        tuple_ch.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Sender idles until every owed hash is back, then lets the pipe settle.
    task automatic drain_results();
        pause_sender(1);
        while (owed_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Seed writes happen only with the pipe empty.
    task automatic write_seed(input logic [WORD_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        seed_shadow = value;
    endtask

    // Random beats in bursts of random length with random gaps between them;
    // about a quarter of the bursts follow the previous one with no gap.
    task automatic send_stream(input int unsigned count);
        int unsigned burst = 0;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 6));
            end
            send_tuple(random_tuple());
            burst--;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The seed comes out of reset as zero; hash a few beats without a write.
    task automatic test_reset_seed();
        send_tuple(make_tuple(KIND_USER, '0, '0, '0, '0));
        send_tuple(make_tuple(KIND_INTERNAL, '0, '0, '0, '0));
        send_stream(10);
    endtask

    // Field extremes and every kind; internal and unknown kinds carry garbage
    // that must not reach the key.
    task automatic test_corner_tuples();
        write_seed('1);
        send_tuple(make_tuple(KIND_USER, '0, '0, '0, '0));
        send_tuple(make_tuple(KIND_USER, '1, '1, '1, '1));
        send_tuple(make_tuple(KIND_USER, '1, 32'd1, '1, 16'd1));
        send_tuple(make_tuple(KIND_USER, 32'd1, '1, 16'd1, '1));
        send_tuple(make_tuple(KIND_USER, 32'h8000_0000, 32'h8000_0000,
                              16'h8000, 16'h8000));
        send_tuple(make_tuple(KIND_USER, 32'hAAAA_AAAA, 32'h5555_5555,
                              16'hAAAA, 16'h5555));
        // equal addresses: the xor word goes to zero
        send_tuple(make_tuple(KIND_USER, 32'hC0A8_0101, 32'hC0A8_0101,
                              16'd443, 16'd443));
        send_tuple(make_tuple(KIND_USER, '0, '1, '1, '0));
        send_tuple(make_tuple(KIND_INTERNAL, '0, '0, '0, '0));
        send_tuple(make_tuple(KIND_INTERNAL, '1, '1, '1, '1));
        send_tuple(make_tuple(KIND_INTERNAL, $urandom, $urandom,
                              PORT_W'($urandom_range(0, 16'hFFFF)),
                              PORT_W'($urandom_range(0, 16'hFFFF))));
        send_tuple(make_tuple(KIND_OTHER, '0, '0, '0, '0));
        send_tuple(make_tuple(KIND_OTHER, '1, '1, '1, '1));
        send_tuple(make_tuple(KIND_OTHER, $urandom, $urandom,
                              PORT_W'($urandom_range(0, 16'hFFFF)),
                              PORT_W'($urandom_range(0, 16'hFFFF))));
        // spare kind code behaves like any other unknown kind
        send_tuple(make_tuple(KIND_SPARE, '0, '0, '0, '0));
        send_tuple(make_tuple(KIND_SPARE, '1, '1, '1, '1));
        send_tuple(make_tuple(KIND_SPARE, $urandom, $urandom,
                              PORT_W'($urandom_range(0, 16'hFFFF)),
                              PORT_W'($urandom_range(0, 16'hFFFF))));
    endtask

    // Seed extremes and single-bit seeds, a short stream under each.
    task automatic test_seed_extremes();
        logic [WORD_W-1:0] seeds[5];
        seeds[0] = '0;
        seeds[1] = 64'd1;
        seeds[2] = 64'h8000_0000_0000_0000;
        seeds[3] = '1;
        seeds[4] = {$urandom, $urandom};
        foreach (seeds[i])
        begin
            write_seed(seeds[i]);
            send_tuple(make_tuple(KIND_USER, '1, '1, '1, '1));
            send_tuple(make_tuple(KIND_INTERNAL, '0, '0, '0, '0));
            send_tuple(make_tuple(KIND_OTHER, '0, '0, '0, '0));
            send_stream(12);
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // back-to-back beats: the pipe fills and the input must stall. Then the
    // sender waits until every hash is back before going on.
    task automatic test_backpressure();
        write_seed({$urandom, $urandom});
        @(negedge clk);
        -> hold_go;
        for (int unsigned i = 0; i < 60; i++)
            send_tuple(random_tuple());
        drain_results();
        send_stream(40);
        drain_results();
    endtask

    // Bulk random traffic over several seeds; the last phase reuses all ones.
    task automatic test_random_traffic();
        for (int unsigned p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
                write_seed('1);
            else
                write_seed({$urandom, $urandom});
            send_stream(RANDOM_ITEMS / RANDOM_PHASES);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall patterns, plus a long hold-off on request
    // ------------------------------------------------------------------

    // Long hold-off, counted here so the sender can keep pushing meanwhile.
    initial
    begin
        forever
        begin
            @(hold_go);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    // Ready changes on the falling edge; the pattern switches after a random
    // stretch so stalls land on every stage of the pipe, and the open
    // pattern gives stretches with no stall at all.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 80);
        end
        else
            rx_left <= rx_left - 1;
        rx_phase <= rx_phase + 1;
        if (!rst_n || hold_active)
            hash_ch.ready <= 1'b0;
        else
        begin
            case (rx_mode)
                RX_OPEN:    hash_ch.ready <= 1'b1;
                RX_COIN:    hash_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:  hash_ch.ready <= ($urandom_range(0, 3) == 0);
                RX_CADENCE: hash_ch.ready <= (rx_phase % 3 != 0);
                default:    hash_ch.ready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each taken beat against the oldest owed hash
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        logic [WORD_W-1:0] want;
        if (rst_n && hash_ch.valid && hash_ch.ready)
        begin
            if (owed_hashes.size() == 0)
            begin
                $display("%0t: unexpected hash beat, expected none, actual %h",
                         $realtime, hash_ch.flow_hash);
                mismatch_count++;
            end
            else
            begin
                want = owed_hashes.pop_front();
                if (hash_ch.flow_hash !== want)
                begin
                    $display("%0t: flow_hash mismatch, expected %h, actual %h",
                             $realtime, want, hash_ch.flow_hash);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d hashes outstanding",
                     $realtime, owed_hashes.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        tuple_ch.valid    = 1'b0;
        tuple_ch.req_type = KIND_USER;
        tuple_ch.src_addr = '0;
        tuple_ch.dst_addr = '0;
        tuple_ch.src_port = '0;
        tuple_ch.dst_port = '0;
        hash_ch.ready     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_seed();
        test_corner_tuples();
        test_seed_extremes();
        test_backpressure();
        test_random_traffic();
        drain_results();

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
